/* rtl/core/rmt_pkg.sv */
// Shared types and constants for the regret-matching table.
// No dependencies; imported by rmt_div and regret_matching_table.
`default_nettype none
package rmt_pkg;
	localparam int MAX_ACTIONS_DEF = 16;
	localparam int REGRET_W = 32;
	localparam int STRAT_W = 48;
	localparam int PROB_W = 17;
	localparam int NUM_W = 5;
	localparam int ADDR_W = 1;
	localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [NUM_W-1:0] NUM_RESET = 5'd16;
	localparam logic [ADDR_W-1:0] REG_ACT_COUNT = 1'b0;

	typedef enum logic [2:0] {
		CMD_CLEAR = 3'd0,
		CMD_ADD = 3'd1,
		CMD_ACC = 3'd2,
		CMD_RD_CUR = 3'd3,
		CMD_RD_AVG = 3'd4
	} cmd_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_IDX = 2'd1;
	localparam logic [1:0] ST_BAD_REACH = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/rmt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/core/rmt_div.sv */
// Restoring divider giving floor(a * 65536 / b) for a <= b, one bit a cycle.
// Depends on rmt_pkg for the probability width.
`default_nettype none
module rmt_div #(
	parameter int TW = 52
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [TW-1:0] dividend,
	input  wire logic [TW-1:0] divisor,
	output logic done,
	output logic [rmt_pkg::PROB_W-1:0] quot
);
	import rmt_pkg::*;

	localparam logic [4:0] LAST_STEP = 5'(PROB_W - 1);

	logic busy_q, done_q, first_q;
	logic [4:0] cnt_q;
	logic [TW-1:0] rem_q, dvs_q;
	logic [PROB_W-1:0] quot_q;
	logic [TW:0] trial;
	logic ge;

	always_comb begin
		trial = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
		ge = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			cnt_q <= '0;
			first_q <= 1'b1;
			quot_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits TW bits
			rem_q <= ge ? TW'(trial - {1'b0, dvs_q}) : TW'(trial);
			quot_q <= {quot_q[PROB_W-2:0], ge};
			cnt_q <= cnt_q + 5'd1;
			first_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

/* rtl/core/regret_matching_table.sv */
// Regret-matching table: sequencer, stores and configuration register.
// Depends on rmt_pkg, rmt_ram and rmt_div.
//
// Usage: one command per input transaction (in_valid/in_stall); results leave
// on the output channel (out_valid/out_stall). The action count is to be
// written over the APB port only while the block is idle (not enforced by
// the block); pready is always high. Clear, add regret and accumulate give
// one result; reads give n results, last set on the final one. Unknown
// commands give none. Clear and error results reach the result register
// through S_EMIT, add regret through S_ADD and S_EMIT. Reads and accumulate
// first sum the entries (S_SUM_RD, then S_SUM_ADD for each), then handle each
// entry with one 17-step pass of the shared divider (S_ENT_RD, S_ENT_DATA,
// S_ENT_DIV, S_USE, and S_ACC_WR for accumulate). With a zero total the
// divider runs once, for the uniform value.
// in_stall is high from acceptance until the sequencer is back in idle; a
// result waiting in the output register does not block the next acceptance.
// When the receiver stalls, the result register holds and the sequencer waits
// before its next result.
// Reset zeroes both stores at once through per-entry valid bits and sets
// the action count to 16; clear zeroes both stores the same way.
`default_nettype none
module regret_matching_table #(
	parameter int MAX_ACTIONS = rmt_pkg::MAX_ACTIONS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [rmt_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [2:0] cmd,
	input  wire logic [3:0] action_index,
	input  wire logic signed [31:0] delta,
	input  wire logic [16:0] reach,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [3:0] out_action,
	output logic [16:0] probability,
	output logic [1:0] status,
	output logic last
);
	import rmt_pkg::*;

	localparam int IW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
	localparam int CW = IW + 1;
	localparam int TW = STRAT_W + IW;

	typedef enum logic [3:0] {
		S_IDLE, S_ADD, S_SUM_RD, S_SUM_ADD, S_UNI, S_ENT_RD,
		S_ENT_DATA, S_ENT_DIV, S_USE, S_ACC_WR, S_EMIT
	} state_t;

	state_t state_q;
	logic [NUM_W-1:0] num_q;
	logic [MAX_ACTIONS-1:0] reg_vld_q, str_vld_q;
	logic reg_vld_s1, str_vld_s1;
	logic [CW-1:0] n_c, n_q, k_q;
	cmd_t cmd_q;
	logic [3:0] idx_q;
	logic [31:0] delta_q;
	logic [PROB_W-1:0] reach_q, p_q, uni_q;
	logic src_strat_q;
	logic [TW-1:0] total_q, total_nx, src_val, pos_val;
	logic [STRAT_W-1:0] strat_q;
	logic [33:0] prod_s1;
	logic [3:0] res_act_q;
	logic [1:0] res_st_q;
	logic out_valid_q, out_last_q;
	logic [3:0] out_act_q;
	logic [PROB_W-1:0] out_prob_q;
	logic [1:0] out_st_q;

	logic [IW-1:0] rd_addr;
	logic [REGRET_W-1:0] reg_ram, reg_rd, reg_wdata;
	logic [STRAT_W-1:0] str_ram, str_rd, str_wdata;
	logic [32:0] sum33;
	logic [48:0] acc_sum;
	logic reg_we, str_we, out_free, out_load, last_k, accept;
	logic div_start, div_done;
	logic [TW-1:0] div_a, div_b;
	logic [PROB_W-1:0] div_q;

	// effective action count
	always_comb begin
		if (num_q == '0) begin
			n_c = CW'(1);
		end else if (32'(num_q) > MAX_ACTIONS) begin
			n_c = CW'(MAX_ACTIONS);
		end else begin
			n_c = CW'(num_q);
		end
	end

	assign accept = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free &&
		(((state_q == S_USE) && (cmd_q != CMD_ACC)) || (state_q == S_EMIT));
	assign last_k = CW'(k_q + 1'b1) == n_q;

	assign rd_addr = (state_q == S_IDLE) ? IW'(action_index) : k_q[IW-1:0];
	assign reg_rd = reg_vld_s1 ? reg_ram : '0;
	assign str_rd = str_vld_s1 ? str_ram : '0;
	assign pos_val = reg_rd[REGRET_W-1] ? '0 : TW'(reg_rd[REGRET_W-2:0]);
	assign src_val = src_strat_q ? TW'(str_rd) : pos_val;
	assign total_nx = total_q + src_val;

	// saturating regret add and saturating strategy accumulate
	always_comb begin
		sum33 = {reg_rd[31], reg_rd} + {delta_q[31], delta_q};
		if (sum33[32] != sum33[31]) begin
			reg_wdata = sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			reg_wdata = sum33[31:0];
		end
		acc_sum = {1'b0, strat_q} + 49'(prod_s1[33:16]);
		str_wdata = acc_sum[48] ? '1 : acc_sum[47:0];
	end

	assign reg_we = (state_q == S_ADD);
	assign str_we = (state_q == S_ACC_WR);

	assign div_start = ((state_q == S_SUM_ADD) && last_k && total_nx == '0) ||
		((state_q == S_ENT_DATA) && total_q != '0);
	assign div_a = (state_q == S_SUM_ADD) ? TW'(1) : src_val;
	assign div_b = (state_q == S_SUM_ADD) ? TW'(n_q) : total_q;

	rmt_ram #(.WIDTH(REGRET_W), .DEPTH(MAX_ACTIONS)) u_regret (
		.clk(clk), .we(reg_we), .waddr(IW'(idx_q)), .wdata(reg_wdata),
		.raddr(rd_addr), .rdata_q(reg_ram)
	);

	rmt_ram #(.WIDTH(STRAT_W), .DEPTH(MAX_ACTIONS)) u_strat (
		.clk(clk), .we(str_we), .waddr(k_q[IW-1:0]), .wdata(str_wdata),
		.raddr(rd_addr), .rdata_q(str_ram)
	);

	rmt_div #(.TW(TW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quot(div_q)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_RESET;
		end else if (psel && penable && pwrite && paddr == REG_ACT_COUNT) begin
			num_q <= pwdata[NUM_W-1:0];
		end
	end
	assign prdata = (paddr == REG_ACT_COUNT) ? {{(32-NUM_W){1'b0}}, num_q} : '0;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			reg_vld_q <= '0;
			str_vld_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd_t'(cmd);
						idx_q <= action_index;
						delta_q <= delta;
						reach_q <= reach;
						n_q <= n_c;
						k_q <= '0;
						total_q <= '0;
						src_strat_q <= (cmd_t'(cmd) == CMD_RD_AVG);
						res_act_q <= '0;
						res_st_q <= ST_OK;
						case (cmd_t'(cmd))
							CMD_CLEAR: begin
								reg_vld_q <= '0;
								str_vld_q <= '0;
								state_q <= S_EMIT;
							end
							CMD_ADD: begin
								res_act_q <= action_index;
								if (32'(action_index) >= 32'(n_c)) begin
									res_st_q <= ST_BAD_IDX;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_ADD;
								end
							end
							CMD_ACC: begin
								if (reach > ONE_Q16) begin
									res_st_q <= ST_BAD_REACH;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_SUM_RD;
								end
							end
							CMD_RD_CUR, CMD_RD_AVG: state_q <= S_SUM_RD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ADD: begin
					reg_vld_q[IW'(idx_q)] <= 1'b1;
					state_q <= S_EMIT;
				end
				S_SUM_RD: state_q <= S_SUM_ADD;
				S_SUM_ADD: begin
					total_q <= total_nx;
					if (last_k) begin
						k_q <= '0;
						state_q <= (total_nx == '0) ? S_UNI : S_ENT_RD;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_SUM_RD;
					end
				end
				S_UNI: begin
					if (div_done) begin
						uni_q <= div_q;
						state_q <= S_ENT_RD;
					end
				end
				S_ENT_RD: state_q <= S_ENT_DATA;
				S_ENT_DATA: begin
					strat_q <= str_rd;
					if (total_q == '0) begin
						p_q <= uni_q;
						state_q <= S_USE;
					end else begin
						state_q <= S_ENT_DIV;
					end
				end
				S_ENT_DIV: begin
					if (div_done) begin
						p_q <= div_q;
						state_q <= S_USE;
					end
				end
				S_USE: begin
					if (cmd_q == CMD_ACC) begin
						prod_s1 <= 34'(reach_q) * 34'(p_q);
						state_q <= S_ACC_WR;
					end else if (out_free) begin
						out_act_q <= 4'(k_q);
						out_prob_q <= p_q;
						out_st_q <= ST_OK;
						out_last_q <= last_k;
						if (last_k) begin
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= S_ENT_RD;
						end
					end
				end
				S_ACC_WR: begin
					str_vld_q[k_q[IW-1:0]] <= 1'b1;
					if (last_k) begin
						state_q <= S_EMIT;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_ENT_RD;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_act_q <= res_act_q;
						out_prob_q <= '0;
						out_st_q <= res_st_q;
						out_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			reg_vld_s1 <= reg_vld_q[rd_addr];
			str_vld_s1 <= str_vld_q[rd_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_action = out_act_q;
	assign probability = out_prob_q;
	assign status = out_st_q;
	assign last = out_last_q;

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (last && probability == '0))
		else $error("error result not a single final transaction");
	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (probability <= ONE_Q16))
		else $error("probability above one");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_UNI || state_q == S_ENT_DIV))
		else $error("divider finished with no one waiting");
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		reg_we |-> !str_we)
		else $error("both stores written at once");
endmodule
`default_nettype wire

/* sim/rmt_strategy_checker.sv */
// Checker for the regret-matching table: watches the APB, command and result channels.
// Keeps its own regret and strategy sums and compares each result with the oldest prediction.
// Depends on rmt_pkg.
`default_nettype none
module rmt_strategy_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [rmt_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic pready,
	input  wire logic in_valid,
	input  wire logic in_stall,
	input  wire logic [2:0] cmd,
	input  wire logic [3:0] action_index,
	input  wire logic signed [31:0] delta,
	input  wire logic [16:0] reach,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire logic [3:0] out_action,
	input  wire logic [16:0] probability,
	input  wire logic [1:0] status,
	input  wire logic last,
	output int mismatches,
	output int pending,
	output int results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import rmt_pkg::*;

	typedef struct packed {
		logic [3:0] act;
		logic [16:0] prob;
		logic [1:0] st;
		logic lst;
	} strat_result_t;

	localparam logic [47:0] STRAT_SAT = 48'hFFFF_FFFF_FFFF;

	logic signed [31:0] regret_tbl [16];
	logic [47:0] strat_tbl [16];
	logic [4:0] act_count_q;
	logic [16:0] prob_buf [16];
	strat_result_t expected_q [$];

	function automatic int eff_actions();
		if (act_count_q == 0) return 1;
		if (act_count_q > 16) return 16;
		return int'(act_count_q);
	endfunction

	// Regret matching over the first n entries into prob_buf.
	function automatic void calc_current(input int n);
		logic [63:0] total;
		logic [63:0] pos;
		total = 0;
		for (int k = 0; k < n; k++)
			if (regret_tbl[k] > 0) total += {32'b0, regret_tbl[k]};
		for (int k = 0; k < n; k++) begin
			if (total == 0) begin
				prob_buf[k] = 17'(65536 / n);
			end else begin
				pos = (regret_tbl[k] > 0) ? {32'b0, regret_tbl[k]} : 64'd0;
				prob_buf[k] = 17'((pos << 16) / total);
			end
		end
	endfunction

	function automatic void calc_average(input int n);
		logic [63:0] total;
		total = 0;
		for (int k = 0; k < n; k++) total += {16'b0, strat_tbl[k]};
		for (int k = 0; k < n; k++) begin
			if (total == 0) prob_buf[k] = 17'(65536 / n);
			else prob_buf[k] = 17'(({16'b0, strat_tbl[k]} << 16) / total);
		end
	endfunction

	function automatic void push_result(input logic [3:0] a, input logic [16:0] p,
			input logic [1:0] s, input logic l);
		strat_result_t r;
		r.act = a;
		r.prob = p;
		r.st = s;
		r.lst = l;
		expected_q = {expected_q, r};
	endfunction

	task automatic predict(input logic [2:0] c, input logic [3:0] idx,
			input logic signed [31:0] d, input logic [16:0] rp);
		int n;
		longint sum;
		logic [63:0] grown;
		n = eff_actions();
		case (c)
			CMD_CLEAR: begin
				for (int k = 0; k < 16; k++) begin
					regret_tbl[k] = 0;
					strat_tbl[k] = 0;
				end
				push_result(4'd0, 17'd0, ST_OK, 1'b1);
			end
			CMD_ADD: begin
				if (int'(idx) >= n) begin
					push_result(idx, 17'd0, ST_BAD_IDX, 1'b1);
				end else begin
					sum = longint'(regret_tbl[idx]) + longint'(d);
					if (sum > 64'sd2147483647) sum = 64'sd2147483647;
					if (sum < -64'sd2147483648) sum = -64'sd2147483648;
					regret_tbl[idx] = 32'(sum);
					push_result(idx, 17'd0, ST_OK, 1'b1);
				end
			end
			CMD_ACC: begin
				if (rp > ONE_Q16) begin
					push_result(4'd0, 17'd0, ST_BAD_REACH, 1'b1);
				end else begin
					calc_current(n);
					for (int k = 0; k < n; k++) begin
						grown = {16'b0, strat_tbl[k]}
							+ (({47'b0, rp} * {47'b0, prob_buf[k]}) >> 16);
						strat_tbl[k] = (grown > {16'b0, STRAT_SAT}) ? STRAT_SAT
							: grown[47:0];
					end
					push_result(4'd0, 17'd0, ST_OK, 1'b1);
				end
			end
			CMD_RD_CUR, CMD_RD_AVG: begin
				if (c == CMD_RD_CUR) calc_current(n);
				else calc_average(n);
				for (int k = 0; k < n; k++)
					push_result(4'(k), prob_buf[k], ST_OK, (k + 1 == n));
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		strat_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) begin
				regret_tbl[k] = 0;
				strat_tbl[k] = 0;
			end
			act_count_q = NUM_RESET;
			expected_q.delete();
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_ACT_COUNT)
				act_count_q = pwdata[4:0];
			// compare before predicting: no result can leave on the edge that took its command
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: action %0d prob %0d status %0d last %0d",
							out_action, probability, status, last);
				end else begin
					want = expected_q.pop_front();
					if (want.act !== out_action || want.prob !== probability
							|| want.st !== status || want.lst !== last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp act %0d prob %0d st %0d last %0d,",
								" got act %0d prob %0d st %0d last %0d"},
								want.act, want.prob, want.st, want.lst,
								out_action, probability, status, last);
					end
				end
			end
			if (in_valid && !in_stall)
				predict(cmd, action_index, delta, reach);
		end
		pending = expected_q.size();
	end
endmodule
`default_nettype wire

/* sim/tb_regret_matching_table.sv */
// Testbench top for the regret-matching table: clock, reset, APB writes and command stimulus.
// Depends on rmt_pkg, regret_matching_table and rmt_strategy_checker.
`default_nettype none
module tb_regret_matching_table;
	timeunit 1ns;
	timeprecision 1ps;
	import rmt_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [2:0] cmd;
	logic [3:0] action_index;
	logic signed [31:0] delta;
	logic [16:0] reach;
	logic out_valid, out_stall;
	logic [3:0] out_action;
	logic [16:0] probability;
	logic [1:0] status;
	logic last;

	int mismatches, pending, results_seen;
	int items_sent;
	int quiet_cycles;
	bit calm;
	logic [4:0] cur_n;

	regret_matching_table DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.action_index(action_index), .delta(delta), .reach(reach),
		.out_valid(out_valid), .out_stall(out_stall), .out_action(out_action),
		.probability(probability), .status(status), .last(last)
	);

	rmt_strategy_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.action_index(action_index), .delta(delta), .reach(reach),
		.out_valid(out_valid), .out_stall(out_stall), .out_action(out_action),
		.probability(probability), .status(status), .last(last),
		.mismatches(mismatches), .pending(pending), .results_seen(results_seen)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(negedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 37);
	end

	// end the run if no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_cmd(input logic [2:0] c, input logic [3:0] idx,
			input logic signed [31:0] d, input logic [16:0] rp);
		logic stalled;
		if (!calm && $urandom_range(0, 99) < 37) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		action_index <= idx;
		delta <= d;
		reach <= rp;
		// sample the stall ahead of each edge, where it is settled
		do begin
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		items_sent++;
	endtask

	// drain outstanding results, let the sequencer settle, then write the action count
	task automatic set_actions(input logic [4:0] n);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (450) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_ACT_COUNT;
		pwdata <= {27'b0, n};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_n = n;
	endtask

	function automatic int eff_n();
		if (cur_n == 0) return 1;
		if (cur_n > 16) return 16;
		return int'(cur_n);
	endfunction

	task automatic random_cmd();
		int pick;
		logic signed [31:0] d;
		pick = $urandom_range(0, 99);
		d = ($urandom_range(0, 1) != 0) ? $signed($urandom)
			: $signed(32'($urandom_range(0, 262143)) - 32'd131072);
		if (pick < 40)
			send_cmd(CMD_ADD, 4'($urandom_range(0, eff_n() - 1)), d, 17'($urandom));
		else if (pick < 58)
			send_cmd(CMD_ACC, 4'($urandom), d, 17'($urandom_range(0, 65536)));
		else if (pick < 72)
			send_cmd(CMD_RD_CUR, 4'($urandom), d, 17'($urandom));
		else if (pick < 84)
			send_cmd(CMD_RD_AVG, 4'($urandom), d, 17'($urandom));
		else if (pick < 89)
			send_cmd(CMD_ADD, 4'($urandom_range(0, 15)), d, 17'($urandom));
		else if (pick < 94)
			send_cmd(CMD_ACC, 4'($urandom), d, 17'($urandom_range(65537, 131071)));
		else if (pick < 97)
			send_cmd(3'($urandom_range(5, 7)), 4'($urandom), d, 17'($urandom));
		else
			send_cmd(CMD_CLEAR, 4'($urandom), d, 17'($urandom));
	endtask

	initial begin
		logic [4:0] settings [6];
		settings = '{5'd3, 5'd16, 5'd1, 5'd9, 5'd0, 5'd31};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		cmd = CMD_CLEAR;
		action_index = '0;
		delta = '0;
		reach = '0;
		calm = 1'b0;
		items_sent = 0;
		cur_n = NUM_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: uniform after reset, saturation both ways, bad index and reach
		send_cmd(CMD_RD_CUR, 4'd0, 32'sd0, 17'd0);
		send_cmd(CMD_RD_AVG, 4'd0, 32'sd0, 17'd0);
		send_cmd(CMD_ADD, 4'd0, 32'sh7FFF_FFFF, 17'd0);
		send_cmd(CMD_ADD, 4'd0, 32'sh7FFF_FFFF, 17'd0);
		send_cmd(CMD_ADD, 4'd1, 32'sh8000_0000, 17'h1FFFF);
		send_cmd(CMD_ADD, 4'd1, 32'sh8000_0000, 17'h1FFFF);
		send_cmd(CMD_ADD, 4'd15, 32'sd65536, 17'd0);
		send_cmd(CMD_ACC, 4'd0, 32'sd0, 17'd0);
		send_cmd(CMD_ACC, 4'd0, 32'sd0, 17'd65536);
		send_cmd(CMD_ACC, 4'd0, 32'sd0, 17'd65537);
		send_cmd(CMD_ACC, 4'd0, 32'sd0, 17'h1FFFF);
		send_cmd(CMD_RD_CUR, 4'd0, 32'sd0, 17'd0);
		send_cmd(CMD_RD_AVG, 4'd0, 32'sd0, 17'd0);
		send_cmd(3'd5, 4'd0, 32'sd0, 17'd0);
		send_cmd(3'd6, 4'd15, -32'sd1, 17'h1FFFF);
		send_cmd(3'd7, 4'd0, 32'sd0, 17'd0);
		send_cmd(CMD_CLEAR, 4'd0, 32'sd0, 17'd0);
		send_cmd(CMD_RD_AVG, 4'd0, 32'sd0, 17'd0);
		set_actions(5'd2);
		send_cmd(CMD_ADD, 4'd2, 32'sd100, 17'd0);
		send_cmd(CMD_ADD, 4'd1, 32'sd100, 17'd0);
		send_cmd(CMD_RD_CUR, 4'd0, 32'sd0, 17'd0);

		// random phases over several action counts, one quiet stretch in the middle
		for (int ph = 0; ph < 6; ph++) begin
			set_actions(settings[ph]);
			calm = (ph == 3);
			for (int i = 0; i < 17; i++) random_cmd();
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (450) @(posedge clk);
		$display("Sent %0d commands across a range of action counts, %0d results checked.",
			items_sent, results_seen);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
